>>> sv/rtkd_pkg.sv
// Shared types and constants for the rapid-trigger key detector.
// No dependencies; imported by every module of the block but rtkd_ram.
`timescale 1ns / 1ps

package rtkd_pkg;

    // Field widths fixed by the item format
    localparam int FIELD_W   = 12;
    localparam int SHIFT_W   = 4;
    localparam int DEV_IN_W  = 4;
    localparam int KEY_W     = 2;
    localparam int KEYS      = 4;
    localparam int OP_W      = 2;

    // Stream channel widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // s_tdata field offsets
    localparam int DEV_LSB    = 0;
    localparam int KEY_LSB    = 4;
    localparam int SAMPLE_LSB = 6;
    localparam int ACT_LSB    = 18;
    localparam int REL_LSB    = 30;
    localparam int RAPID_BIT  = 42;
    localparam int FRAME_LSB  = 43;

    // APB
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_SAMPLE_SHIFT = 1'b0;   // word index of sample_shift

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE = 2'd0,
        OP_STORE  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        logic               pressed;
        logic [FIELD_W-1:0] anchor;
    } key_state_t;

    typedef struct packed {
        logic               primed;
        logic               rapid;
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] act;
        logic [FIELD_W-1:0] rel;
        logic [FIELD_W-1:0] delta;
        logic [FIELD_W-1:0] prev;
        key_state_t         old;
    } key_eval_in_t;

endpackage

>>> sv/rapid_trigger_key_detector_core.sv
// Rapid-trigger key detector: top level. Sustains one item per clock while
// the output is not stalled; an item's result passes through the RAM read
// register, then the output register. Throughput is set by the single
// read-modify-write pass through the key state RAM: reads issue at acceptance,
// writes at the following commit, and a same-entry write in that cycle is forwarded.
// The pressed/anchor store and the per-device last-sample store live in two
// 1R1W RAMs; clear items take effect through per-key and per-device valid
// flops, so no clearing pass is needed after reset or clear.
// Depends on rtkd_pkg, rtkd_ram and rtkd_key_eval.
`timescale 1ns / 1ps

module rapid_trigger_key_detector_core #(
    parameter int DEVICES     = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // item in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [3:0] dev_sel, [5:4] key_sel, [17:6] sample_value,
    // [29:18] actuation_raw, [41:30] release_raw, [42] rapid_enable,
    // [54:43] frame_value_0, [66:55] frame_value_1, [78:67] frame_value_2,
    // [90:79] frame_value_3, [95:91] zero
    input  logic [rtkd_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] operation
    input  logic [rtkd_pkg::S_TUSER_W-1:0]  s_tuser,
    // item out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] key_pressed, [1] device_primed, [7:2] zero
    output logic [rtkd_pkg::M_TDATA_W-1:0]  m_tdata,
    // APB config
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rtkd_pkg::APB_AW-1:0]     paddr,
    input  logic [rtkd_pkg::APB_DW-1:0]     pwdata,
    output logic [rtkd_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import rtkd_pkg::*;

    localparam int VW     = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam int DW     = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int SW     = DW + KEY_W;
    localparam int SLOTS  = DEVICES * KEYS;
    localparam int ST_W   = 1 + VW;
    localparam int ROW_W  = KEYS * VW;
    localparam logic [7:0] DEV_LIMIT = 8'(DEVICES);

    // ---------------- configuration ----------------
    logic               cfg_wr;
    logic [SHIFT_W-1:0] shift_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
        end else if (cfg_wr && paddr[2] == REG_SAMPLE_SHIFT) begin
            shift_reg <= pwdata[SHIFT_W-1:0];
        end
    end

    // only one register; address bits below the word index are ignored
    assign prdata = (paddr[2] == REG_SAMPLE_SHIFT) ? APB_DW'(shift_reg) : '0;

    // ---------------- input decode ----------------
    logic                         accept;
    op_t                          op_in;
    logic [DEV_IN_W-1:0]          dev_raw;
    logic [DW+DEV_IN_W-1:0]       dev_ext;
    logic [DW-1:0]                dev_in;
    logic                         in_range_in;
    logic [KEY_W-1:0]             key_in;
    logic [SW-1:0]                slot_in;
    logic [FIELD_W-1:0]           act_sh, rel_sh, act_in, rel_in, diff_in, delta_in;
    logic [KEYS-1:0][VW-1:0]      frames_in;

    assign accept  = s_tvalid && s_tready;
    assign op_in   = op_t'(s_tuser[OP_W-1:0]);
    assign dev_raw = s_tdata[DEV_LSB +: DEV_IN_W];
    assign dev_ext = {{DW{1'b0}}, dev_raw};
    assign dev_in  = dev_ext[DW-1:0];
    assign in_range_in = {4'b0, dev_raw} < DEV_LIMIT;
    assign key_in  = s_tdata[KEY_LSB +: KEY_W];
    assign slot_in = {dev_in, key_in};

    // point shift and ordering happen before the RAM data returns
    always_comb begin
        act_sh = s_tdata[ACT_LSB +: FIELD_W] >> shift_reg;
        rel_sh = s_tdata[REL_LSB +: FIELD_W] >> shift_reg;
        if (act_sh < rel_sh) begin
            act_in = rel_sh;
            rel_in = act_sh;
        end else begin
            act_in = act_sh;
            rel_in = rel_sh;
        end
        diff_in  = act_in - rel_in;
        delta_in = (diff_in == '0) ? FIELD_W'(1) : diff_in;
        for (int k = 0; k < KEYS; k++) begin
            frames_in[k] = s_tdata[FRAME_LSB + k*FIELD_W +: VW];
        end
    end

    // ---------------- stage 1: RAM data valid ----------------
    logic                    s1_valid_reg;
    op_t                     s1_op_reg;
    logic [DW-1:0]           s1_dev_reg;
    logic [KEY_W-1:0]        s1_key_reg;
    logic                    s1_in_range_reg;
    logic [VW-1:0]           s1_value_reg;
    logic                    s1_rapid_reg;
    logic [FIELD_W-1:0]      s1_act_reg, s1_rel_reg, s1_delta_reg;
    logic [KEYS-1:0][VW-1:0] s1_frames_reg;
    logic                    s1_fwd_st_reg, s1_fwd_row_reg;
    logic [ST_W-1:0]         st_hold_reg;
    logic [KEYS-1:0][VW-1:0] row_hold_reg;

    logic                    s1_adv, commit;
    logic                    is_upd, is_store, is_clear;
    logic [SW-1:0]           s1_slot;

    assign s1_adv   = !m_tvalid || m_tready;
    assign commit   = s1_valid_reg && s1_adv;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s1_slot  = {s1_dev_reg, s1_key_reg};
    assign is_upd   = (s1_op_reg == OP_UPDATE) && s1_in_range_reg;
    assign is_store = (s1_op_reg == OP_STORE) && s1_in_range_reg;
    assign is_clear = (s1_op_reg == OP_CLEAR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg       <= op_in;
            s1_dev_reg      <= dev_in;
            s1_key_reg      <= key_in;
            s1_in_range_reg <= in_range_in;
            s1_value_reg    <= s_tdata[SAMPLE_LSB +: VW];
            s1_rapid_reg    <= s_tdata[RAPID_BIT];
            s1_act_reg      <= act_in;
            s1_rel_reg      <= rel_in;
            s1_delta_reg    <= delta_in;
            s1_frames_reg   <= frames_in;
            // entry written at this very edge: RAM read returns old data
            s1_fwd_st_reg   <= commit && is_upd && (s1_slot == slot_in);
            s1_fwd_row_reg  <= commit && is_store && (s1_dev_reg == dev_in);
        end
    end

    // ---------------- stores ----------------
    logic [ST_W-1:0]         st_rd, st_wr, st_raw;
    logic [ROW_W-1:0]        row_rd;
    logic [KEYS-1:0][VW-1:0] row_sel;
    key_state_t              ev_out;
    key_eval_in_t            ev_in;

    rtkd_ram #(
        .WIDTH (ST_W),
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (commit && is_upd),
        .wr_addr (s1_slot),
        .wr_data (st_wr),
        .rd_en   (accept),
        .rd_addr (slot_in),
        .rd_data (st_rd)
    );

    rtkd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEVICES),
        .AW    (DW)
    ) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (commit && is_store),
        .wr_addr (s1_dev_reg),
        .wr_data (ROW_W'(s1_frames_reg)),
        .rd_en   (accept),
        .rd_addr (dev_in),
        .rd_data (row_rd)
    );

    always_ff @(posedge aclk) begin
        if (commit) begin
            st_hold_reg  <= st_wr;
            row_hold_reg <= s1_frames_reg;
        end
    end

    // valid flops: an invalid key reads as released with anchor zero
    logic [SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    logic [DEVICES-1:0] dev_valid_reg, dev_valid_next;
    logic               slot_ok, primed;

    always_comb begin
        slot_valid_next = slot_valid_reg;
        dev_valid_next  = dev_valid_reg;
        if (commit) begin
            if (is_clear) begin
                slot_valid_next = '0;
                dev_valid_next  = '0;
            end else if (is_upd) begin
                slot_valid_next[s1_slot] = 1'b1;
            end else if (is_store) begin
                dev_valid_next[s1_dev_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            dev_valid_reg  <= '0;
        end else begin
            slot_valid_reg <= slot_valid_next;
            dev_valid_reg  <= dev_valid_next;
        end
    end

    assign slot_ok = s1_in_range_reg && slot_valid_reg[s1_slot];
    assign primed  = s1_in_range_reg && dev_valid_reg[s1_dev_reg];
    assign st_raw  = s1_fwd_st_reg ? st_hold_reg : st_rd;
    assign row_sel = s1_fwd_row_reg ? row_hold_reg : row_rd;

    always_comb begin
        ev_in.primed      = primed;
        ev_in.rapid       = s1_rapid_reg;
        ev_in.value       = FIELD_W'(s1_value_reg);
        ev_in.act         = s1_act_reg;
        ev_in.rel         = s1_rel_reg;
        ev_in.delta       = s1_delta_reg;
        ev_in.prev        = FIELD_W'(row_sel[s1_key_reg]);
        ev_in.old.pressed = slot_ok && st_raw[VW];
        ev_in.old.anchor  = slot_ok ? FIELD_W'(st_raw[VW-1:0]) : '0;
    end

    rtkd_key_eval u_key_eval (
        .ev_i (ev_in),
        .st_o (ev_out)
    );

    assign st_wr = {ev_out.pressed, ev_out.anchor[VW-1:0]};

    // ---------------- output register ----------------
    logic m_valid_reg, m_valid_next;
    logic m_pressed_reg, m_primed_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_pressed_reg <= is_upd && ev_out.pressed;
            m_primed_reg  <= (is_upd || is_store) && primed;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W-2)'(0), m_primed_reg, m_pressed_reg};

endmodule

>>> sv/rtkd_ram.sv
// Simple dual-port RAM, one write and one registered read port.
// No package dependency; used for the key state and last-sample stores.
`timescale 1ns / 1ps

module rtkd_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/rtkd_key_eval.sv
// Next pressed state and anchor of one key (fixed and rapid-trigger modes).
// Depends on rtkd_pkg for the key state structs.
`timescale 1ns / 1ps

module rtkd_key_eval (
    input  rtkd_pkg::key_eval_in_t ev_i,
    output rtkd_pkg::key_state_t   st_o
);
    import rtkd_pkg::*;

    logic [FIELD_W-1:0] hi_anchor;
    logic [FIELD_W-1:0] lo_anchor;
    logic [FIELD_W:0]   rise_lim;

    always_comb begin
        hi_anchor = (ev_i.value > ev_i.old.anchor) ? ev_i.value : ev_i.old.anchor;
        lo_anchor = (ev_i.value < ev_i.old.anchor) ? ev_i.value : ev_i.old.anchor;
        // no wrap on the press threshold
        rise_lim  = {1'b0, lo_anchor} + {1'b0, ev_i.delta};

        st_o = ev_i.old;
        if (!ev_i.primed) begin
            st_o.pressed = 1'b0;
            st_o.anchor  = ev_i.value;
        end else if (!ev_i.rapid) begin
            // plain hysteresis
            st_o.pressed = ev_i.old.pressed ? (ev_i.value > ev_i.rel)
                                            : (ev_i.value >= ev_i.act);
            st_o.anchor  = ev_i.value;
        end else if (ev_i.value < ev_i.act) begin
            st_o.pressed = 1'b0;
            st_o.anchor  = ev_i.value;
        end else if (ev_i.prev < ev_i.act) begin
            // just entered the zone
            st_o.pressed = 1'b1;
            st_o.anchor  = ev_i.value;
        end else if (ev_i.old.pressed) begin
            if (hi_anchor >= ev_i.delta && ev_i.value <= hi_anchor - ev_i.delta) begin
                st_o.pressed = 1'b0;
                st_o.anchor  = ev_i.value;
            end else begin
                st_o.pressed = 1'b1;
                st_o.anchor  = hi_anchor;
            end
        end else begin
            if ({1'b0, ev_i.value} >= rise_lim) begin
                st_o.pressed = 1'b1;
                st_o.anchor  = ev_i.value;
            end else begin
                st_o.pressed = 1'b0;
                st_o.anchor  = lo_anchor;
            end
        end
    end

endmodule

>>> sv/rtkd_checker.sv
// Port-level checks for the rapid-trigger key detector, bound to the top.
// Depends on rtkd_pkg for port widths.
`timescale 1ns / 1ps

module rtkd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rtkd_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [rtkd_pkg::APB_AW-1:0]     paddr,
    input logic [rtkd_pkg::APB_DW-1:0]     pwdata,
    input logic [rtkd_pkg::APB_DW-1:0]     prdata,
    input logic                            pready
);
    import rtkd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a key can only be pressed on a primed device
    a_press_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
        else $error("key pressed on unprimed device");

    // empty output side never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

    // sync reset drops the result
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // shift register reads back what was written
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[2] == REG_SAMPLE_SHIFT)
        ##1 (psel && !pwrite && paddr[2] == REG_SAMPLE_SHIFT)
        |-> prdata == APB_DW'($past(pwdata[SHIFT_W-1:0])))
        else $error("sample_shift readback mismatch");

endmodule

bind rapid_trigger_key_detector_core rtkd_checker u_rtkd_checker (.*);

>>> dv/rtkd_checker.sv
// Scoreboard for the rapid-trigger key detector: tracks register writes and
// accepted items, predicts each result and compares results in order.
// Depends on rtkd_pkg.
`timescale 1ns / 1ps

module rtkd_scoreboard #(
    parameter int DEVICES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [rtkd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [rtkd_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rtkd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rtkd_pkg::APB_AW-1:0]     paddr,
    input  logic [rtkd_pkg::APB_DW-1:0]     pwdata,
    input  logic                            pready,
    output int                              mismatches,
    output int                              pending_results
);
    import rtkd_pkg::*;

    localparam int SLOTS = DEVICES * KEYS;
    localparam logic [APB_AW-1:0] SHIFT_ADDR = {REG_SAMPLE_SHIFT, 2'b00};

    typedef struct packed {
        logic pressed;
        logic primed;
    } key_result_t;

    logic [SHIFT_W-1:0] shift_reg;
    logic [FIELD_W-1:0] last_sample [SLOTS];
    logic               dev_primed  [DEVICES];
    logic               key_down    [SLOTS];
    logic [FIELD_W-1:0] key_anchor  [SLOTS];
    key_result_t        expected_results [$];
    int                 error_count = 0;
    int                 result_count = 0;

    assign mismatches = error_count;

    // Applies one item to the shadow key state and returns its result.
    function automatic key_result_t predict_result(logic [S_TUSER_W-1:0] op_code,
                                                   logic [S_TDATA_W-1:0] data);
        key_result_t res;
        int          dev, slot, act, rel, delta, anchor, prev, v, tmp;
        logic        down;
        res = '0;
        dev = int'(data[DEV_LSB +: DEV_IN_W]);
        case (op_code)
            OP_CLEAR: begin
                for (int i = 0; i < DEVICES; i++)
                    dev_primed[i] = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    key_down[i]   = 1'b0;
                    key_anchor[i] = '0;
                end
            end
            OP_UPDATE, OP_STORE: if (dev < DEVICES) begin
                res.primed = dev_primed[dev];
                if (op_code == OP_STORE) begin
                    for (int k = 0; k < KEYS; k++)
                        last_sample[dev*KEYS + k] = data[FRAME_LSB + k*FIELD_W +: FIELD_W];
                    dev_primed[dev] = 1'b1;
                end else begin
                    slot = dev*KEYS + int'(data[KEY_LSB +: KEY_W]);
                    v    = int'(data[SAMPLE_LSB +: FIELD_W]);
                    act  = int'(data[ACT_LSB +: FIELD_W] >> shift_reg);
                    rel  = int'(data[REL_LSB +: FIELD_W] >> shift_reg);
                    if (act < rel) begin
                        tmp = act;
                        act = rel;
                        rel = tmp;
                    end
                    delta = (act == rel) ? 1 : act - rel;
                    if (!res.primed) begin
                        // no last samples yet: drop press, anchor at the sample
                        key_down[slot]   = 1'b0;
                        key_anchor[slot] = FIELD_W'(v);
                    end else begin
                        down   = key_down[slot];
                        anchor = int'(key_anchor[slot]);
                        prev   = int'(last_sample[slot]);
                        if (!data[RAPID_BIT]) begin
                            down   = down ? (v > rel) : (v >= act);
                            anchor = v;
                        end else if (v < act) begin
                            down   = 1'b0;
                            anchor = v;
                        end else if (prev < act) begin
                            down   = 1'b1;
                            anchor = v;
                        end else if (down) begin
                            if (v > anchor)
                                anchor = v;
                            if (anchor >= delta && v <= anchor - delta) begin
                                down   = 1'b0;
                                anchor = v;
                            end
                        end else begin
                            if (v < anchor)
                                anchor = v;
                            if (v >= anchor + delta) begin
                                down   = 1'b1;
                                anchor = v;
                            end
                        end
                        key_down[slot]   = down;
                        key_anchor[slot] = FIELD_W'(anchor);
                    end
                    res.pressed = key_down[slot];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        key_result_t got, want;
        bit          have_want;
        if (!aresetn) begin
            shift_reg = '0;
            for (int i = 0; i < DEVICES; i++)
                dev_primed[i] = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                last_sample[i] = '0;
                key_down[i]    = 1'b0;
                key_anchor[i]  = '0;
            end
            expected_results.delete();
            pending_results <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == SHIFT_ADDR)
                shift_reg = pwdata[SHIFT_W-1:0];
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_result(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                // m_tdata: [0] key_pressed, [1] device_primed
                got.pressed = m_tdata[0];
                got.primed  = m_tdata[1];
                have_want   = (expected_results.size() != 0);
                want        = '0;
                if (have_want)
                    want = expected_results.pop_front();
                if (!have_want || got !== want) begin
                    if (error_count < 10)
                        $display("%0t result %0d: expected %s, got pressed=%0b primed=%0b",
                                 $time, result_count,
                                 have_want ? $sformatf("pressed=%0b primed=%0b",
                                                       want.pressed, want.primed)
                                           : "nothing",
                                 got.pressed, got.primed);
                    error_count++;
                end
                result_count++;
            end
            pending_results <= expected_results.size();
        end
    end

endmodule

>>> dv/rapid_trigger_key_detector_core_tb.sv
// Testbench top for rapid_trigger_key_detector_core: clock, reset, APB
// writes, item stimulus and random back-pressure, plus the final verdict.
// Depends on rtkd_pkg, the core RTL and rtkd_scoreboard.
`timescale 1ns / 1ps

module rapid_trigger_key_detector_core_tb;
    import rtkd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 5;
    // Slowest legal run is roughly 1100 items; the limit leaves a wide margin.
    localparam int CYCLE_LIMIT    = 400000;
    localparam int TAIL_CYCLES    = 16;      // margin after the last result is taken
    localparam int RX_HOLD_CYCLES = 60;
    localparam int SEGMENTS       = 9;
    localparam int SEGMENT_ITEMS  = 110;
    localparam int SLOTS          = 16 * KEYS;
    localparam int SAMPLE_MAX     = (1 << FIELD_W) - 1;
    localparam logic [S_TUSER_W-1:0] OP_RESERVED = 2'd3;   // not decoded, ignored
    localparam logic [APB_AW-1:0]    SHIFT_ADDR  = {REG_SAMPLE_SHIFT, 2'b00};

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int mismatches;
    int pending_results;
    int cycle_count;

    // idle percentages per side; the receiver hold is requested by count
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;

    // per-key stimulus profile: raw points, mode and current travel
    logic [SHIFT_W-1:0] shift_now = '0;
    logic [FIELD_W-1:0] act_raw_of [SLOTS];
    logic [FIELD_W-1:0] rel_raw_of [SLOTS];
    logic               rapid_of   [SLOTS];
    int                 level_of   [SLOTS];

    rapid_trigger_key_detector_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rtkd_scoreboard u_scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always #CLK_HALF aclk = ~aclk;

    // Receiver: random stalls, plus a long hold when one is requested. The
    // hold counts down here so the sender keeps pushing meanwhile.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            m_tready   <= 1'b0;
            holds_done <= holds_done + 1;
            hold_left  <= RX_HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: a hang or a lost result ends the run here.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("FAIL rapid_trigger_key_detector_core");
        $finish;
    end

    // Offer one item, with random idle cycles first; returns at the edge that
    // accepts it. tvalid is only lowered while idling, never per item.
    task automatic send_item(input logic [S_TUSER_W-1:0] op,
                             input logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Random fill for the fields an item does not use; padding stays zero.
    function automatic logic [S_TDATA_W-1:0] random_payload();
        logic [S_TDATA_W-1:0] d;
        d = {$urandom, $urandom, $urandom};
        d[S_TDATA_W-1:FRAME_LSB + KEYS*FIELD_W] = '0;
        return d;
    endfunction

    task automatic send_update(input int dev, input int key, input logic [FIELD_W-1:0] sample,
                               input logic [FIELD_W-1:0] act_raw,
                               input logic [FIELD_W-1:0] rel_raw, input logic rapid);
        logic [S_TDATA_W-1:0] d;
        d = random_payload();
        d[DEV_LSB +: DEV_IN_W]  = DEV_IN_W'(dev);
        d[KEY_LSB +: KEY_W]     = KEY_W'(key);
        d[SAMPLE_LSB +: FIELD_W] = sample;
        d[ACT_LSB +: FIELD_W]   = act_raw;
        d[REL_LSB +: FIELD_W]   = rel_raw;
        d[RAPID_BIT]            = rapid;
        send_item(OP_UPDATE, d);
    endtask

    // frames packed key 0 in the low 12 bits
    task automatic send_store(input int dev, input logic [KEYS*FIELD_W-1:0] frames);
        logic [S_TDATA_W-1:0] d;
        d = random_payload();
        d[DEV_LSB +: DEV_IN_W]        = DEV_IN_W'(dev);
        d[FRAME_LSB +: KEYS*FIELD_W]  = frames;
        send_item(OP_STORE, d);
    endtask

    // Sender goes quiet until every outstanding result has been taken.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
    endtask

    // APB write of sample_shift: setup cycle, then access cycle.
    task automatic write_shift(input logic [SHIFT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SHIFT_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shift_now = value;
    endtask

    // New raw points, mode and travel for a key: equal points, a narrow gap or anything.
    function automatic void new_profile(int slot);
        act_raw_of[slot] = FIELD_W'($urandom);
        case ($urandom_range(3))
            0:       rel_raw_of[slot] = act_raw_of[slot];
            1:       rel_raw_of[slot] = act_raw_of[slot] - FIELD_W'($urandom_range(64));
            default: rel_raw_of[slot] = FIELD_W'($urandom);
        endcase
        rapid_of[slot] = ($urandom_range(9) < 7);
        level_of[slot] = int'(act_raw_of[slot] >> shift_now);
    endfunction

    // Travel walk around the shifted zone: steps of about the hysteresis
    // width, sometimes a re-center near actuation, rarely a full-range jump.
    function automatic logic [FIELD_W-1:0] next_level(int slot);
        int act, rel, span;
        act  = int'(act_raw_of[slot] >> shift_now);
        rel  = int'(rel_raw_of[slot] >> shift_now);
        span = (act > rel ? act - rel : rel - act) + 2;
        case ($urandom_range(19))
            0:       level_of[slot] = int'($urandom_range(SAMPLE_MAX));
            1, 2:    level_of[slot] = (act > rel ? act : rel) + int'($urandom_range(span))
                                      - span / 2;
            default: level_of[slot] = level_of[slot] + int'($urandom_range(2 * span)) - span;
        endcase
        if (level_of[slot] < 0)
            level_of[slot] = 0;
        if (level_of[slot] > SAMPLE_MAX)
            level_of[slot] = SAMPLE_MAX;
        return FIELD_W'(level_of[slot]);
    endfunction

    // Last-value frame for a device: half the time the current travel of each key,
    // so later rapid updates see a previous sample inside the zone.
    function automatic logic [KEYS*FIELD_W-1:0] recent_frames(int dev);
        logic [KEYS*FIELD_W-1:0] f;
        for (int k = 0; k < KEYS; k++) begin
            case ($urandom_range(3))
                0, 1:    f[k*FIELD_W +: FIELD_W] = FIELD_W'(level_of[dev*KEYS + k]);
                2:       f[k*FIELD_W +: FIELD_W] = FIELD_W'($urandom);
                default: f[k*FIELD_W +: FIELD_W] = $urandom_range(1) ? FIELD_W'(SAMPLE_MAX) : '0;
            endcase
        end
        return f;
    endfunction

    // One random segment: two working devices get stored first, then a mix
    // of updates (mostly on those), stores, rare clears and ignored codes.
    task automatic run_segment(input bit with_hold, input bit with_pause);
        int dev_a, dev_b, dev, key, slot, pick;
        dev_a = $urandom_range(15);
        dev_b = $urandom_range(15);
        for (int k = 0; k < KEYS; k++) begin
            new_profile(dev_a*KEYS + k);
            new_profile(dev_b*KEYS + k);
        end
        send_store(dev_a, recent_frames(dev_a));
        send_store(dev_b, recent_frames(dev_b));
        if (with_hold)
            hold_requests <= hold_requests + 1;
        for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            if (with_pause && n == SEGMENT_ITEMS / 2)
                wait_results_done();
            pick = $urandom_range(99);
            dev  = ($urandom_range(5) == 0) ? int'($urandom_range(15))
                                            : ($urandom_range(1) ? dev_a : dev_b);
            if (pick == 0) begin
                send_item(OP_CLEAR, random_payload());
            end else if (pick < 3) begin
                send_item(OP_RESERVED, random_payload());
            end else if (pick < 11) begin
                send_store(dev, recent_frames(dev));
            end else begin
                key  = $urandom_range(KEYS - 1);
                slot = dev*KEYS + key;
                send_update(dev, key, next_level(slot), act_raw_of[slot], rel_raw_of[slot],
                            rapid_of[slot]);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++)
            new_profile(i);
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_shift('0);

        // ---- directed part, shift 0 ----
        // update before any store: device not primed, press dropped
        send_update(0, 0, FIELD_W'(SAMPLE_MAX), FIELD_W'(SAMPLE_MAX), '0, 1'b1);
        send_item(OP_RESERVED, random_payload());
        // dev 0 last values: key0 0, key1/2 full travel, key3 low
        send_store(0, {12'd100, 12'd4095, 12'd4095, 12'd0});
        send_store(15, {KEYS*FIELD_W{1'b1}});
        // fixed mode: press at actuation, hold inside hysteresis, release at release point
        send_update(0, 0, 12'd4095, 12'd2000, 12'd1000, 1'b0);
        send_update(0, 0, 12'd1500, 12'd2000, 12'd1000, 1'b0);
        send_update(0, 0, 12'd1000, 12'd2000, 12'd1000, 1'b0);
        // rapid, points given out of order: press by delta from the anchor,
        // anchor follows up, then dropping below actuation releases
        send_update(0, 1, 12'd3500, 12'd1000, 12'd3000, 1'b1);
        send_update(0, 1, 12'd4095, 12'd1000, 12'd3000, 1'b1);
        send_update(0, 1, 12'd2500, 12'd1000, 12'd3000, 1'b1);
        // equal points: delta forced to 1, flips on single-step moves
        send_update(0, 2, 12'd3000, 12'd2048, 12'd2048, 1'b1);
        send_update(0, 2, 12'd3500, 12'd2048, 12'd2048, 1'b1);
        send_update(0, 2, 12'd3499, 12'd2048, 12'd2048, 1'b1);
        send_update(0, 2, 12'd3400, 12'd2048, 12'd2048, 1'b1);
        send_update(0, 2, 12'd3401, 12'd2048, 12'd2048, 1'b1);
        // previous sample below actuation: press on entering the zone
        send_update(0, 3, 12'd2500, 12'd2000, 12'd1900, 1'b1);
        // fixed press with actuation 0 leaves anchor 0; rapid release then
        // needs anchor >= delta and must not fire
        send_update(15, 0, 12'd0, 12'd0, 12'd0, 1'b0);
        send_update(15, 0, 12'd0, 12'd0, 12'd0, 1'b1);
        send_item(OP_CLEAR, random_payload());
        send_update(15, 0, 12'd4095, 12'd0, 12'd4095, 1'b1);
        send_store(3, {12'd0, 12'd4095, 12'd2048, 12'd4095});

        // shift past the point width: both points shift to zero
        wait_results_done();
        write_shift(4'd15);
        send_update(3, 0, 12'd0, 12'd4095, 12'd4095, 1'b0);
        send_update(3, 1, 12'd4095, 12'd4095, 12'd0, 1'b1);
        send_update(3, 2, 12'd0, 12'd4095, 12'd0, 1'b1);
        wait_results_done();
        write_shift(4'd11);
        send_update(3, 3, 12'd1, 12'd4095, 12'd0, 1'b1);

        // ---- random part ----
        // idling: sender 34 / receiver 79, then swapped, then none; the long
        // receiver hold and the sender pause land in the no-idle segments
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_results_done();
            write_shift(SHIFT_W'((seg * 5) % 12));
            case (seg / 3)
                0: begin
                    tx_idle_pct = 34;
                    rx_idle_pct <= 79;
                end
                1: begin
                    tx_idle_pct = 79;
                    rx_idle_pct <= 34;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            run_segment(seg == 6, seg == 7);
        end

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results == 0)
            $display("PASS rapid_trigger_key_detector_core");
        else
            $display("FAIL rapid_trigger_key_detector_core");
        $finish;
    end

endmodule

>>> filelist.f
sv/rtkd_pkg.sv
sv/rtkd_ram.sv
sv/rtkd_key_eval.sv
sv/rapid_trigger_key_detector_core.sv
sv/rtkd_checker.sv
dv/rtkd_checker.sv
dv/rapid_trigger_key_detector_core_tb.sv
